FILE: rtl/core/offset_cursor_byte_ring_log_core_macros.svh
// ----------------------------------------------------------------------------
// offset cursor byte ring log assertion macros
// shared property shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef OFFSET_CURSOR_BYTE_RING_LOG_CORE_MACROS_SVH
`define OFFSET_CURSOR_BYTE_RING_LOG_CORE_MACROS_SVH

// same-cycle implication
`define OCBRL_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ocbrl same-cycle check failed");

// next-cycle implication
`define OCBRL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ocbrl next-cycle check failed");

`endif

FILE: rtl/core/ocbrl_pkg.sv
// ----------------------------------------------------------------------------
// ocbrl_pkg
// shared types and constants of the offset cursor byte ring log
// ----------------------------------------------------------------------------
`default_nettype none

package ocbrl_pkg;

  localparam int RingBytesDef = 4096;
  localparam int MaxReadDef   = 64;

  localparam int DataW = 8;
  localparam int OffW  = 64;
  localparam int LimW  = 7;
  localparam int UsedW = 13;

  // operation codes
  localparam logic OpAppend = 1'b0;
  localparam logic OpRead   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_COUNT,
    S_SUM,
    S_EMPTY,
    S_STREAM
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic app;
    logic rd_acc;
    logic clamp;
    logic count;
    logic sum;
    logic issue;
    logic ld_byte;
    logic ld_empty;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic rem_zero;
    logic rv;
    logic out_free;
    logic last_left;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/offset_cursor_byte_ring_log_core.sv
// an append goes straight to the ring, and a new item is taken every cycle while idle
// a read stalls the input through three setup steps (clamp, count and end
// cursor), then streams one byte per cycle while the output is not stalled
// from the ring's single registered read port through the read data stage
// an empty read stalls the input until its result is loaded; reset clears the write offset,
// the ring contents stay undefined until written and no clearing pass runs
// ----------------------------------------------------------------------------
// offset_cursor_byte_ring_log_core
// circular trace buffer addressed by absolute 64-bit byte offsets
// ----------------------------------------------------------------------------
`default_nettype none

module offset_cursor_byte_ring_log_core #(
  parameter int RING_BYTES = ocbrl_pkg::RingBytesDef,
  parameter int MAX_READ   = ocbrl_pkg::MaxReadDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input transaction channel
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic                         operation_i,
  input  wire logic [ocbrl_pkg::DataW-1:0]  byte_in_i,
  input  wire logic [ocbrl_pkg::OffW-1:0]   cursor_in_i,
  input  wire logic [ocbrl_pkg::LimW-1:0]   read_limit_i,
  // result transaction channel
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [ocbrl_pkg::DataW-1:0]  data_out_o,
  output      logic                         byte_valid_o,
  output      logic                         last_o,
  output      logic [ocbrl_pkg::OffW-1:0]   new_cursor_o,
  output      logic [ocbrl_pkg::OffW-1:0]   missed_bytes_o,
  output      logic [ocbrl_pkg::LimW-1:0]   read_count_o,
  output      logic [ocbrl_pkg::OffW-1:0]   oldest_offset_o,
  output      logic [ocbrl_pkg::UsedW-1:0]  bytes_used_o
);
  import ocbrl_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // the sequencer only takes transactions in idle; appends go straight to
  // the ring, reads walk clamp -> count -> end cursor -> stream (or empty result)
  ocbrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // the datapath holds the ring, the write offset, the window math and a
  // read data stage feeding the output register, so streaming advances one
  // byte per cycle whenever the result side is not stalled
  ocbrl_datapath #(
    .RING_BYTES (RING_BYTES),
    .MAX_READ   (MAX_READ)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .byte_in_i       (byte_in_i),
    .cursor_in_i     (cursor_in_i),
    .read_limit_i    (read_limit_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .data_out_o      (data_out_o),
    .byte_valid_o    (byte_valid_o),
    .last_o          (last_o),
    .new_cursor_o    (new_cursor_o),
    .missed_bytes_o  (missed_bytes_o),
    .read_count_o    (read_count_o),
    .oldest_offset_o (oldest_offset_o),
    .bytes_used_o    (bytes_used_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ocbrl_datapath.sv
// ----------------------------------------------------------------------------
// ocbrl_datapath
// ring memory, offset registers, read window math and output register
// ----------------------------------------------------------------------------
`default_nettype none

module ocbrl_datapath #(
  parameter int RING_BYTES = ocbrl_pkg::RingBytesDef,
  parameter int MAX_READ   = ocbrl_pkg::MaxReadDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ocbrl_pkg::cmd_t              cmd_i,
  output      ocbrl_pkg::sts_t              sts_o,
  input  wire logic [ocbrl_pkg::DataW-1:0]  byte_in_i,
  input  wire logic [ocbrl_pkg::OffW-1:0]   cursor_in_i,
  input  wire logic [ocbrl_pkg::LimW-1:0]   read_limit_i,
  input  wire logic                         out_stall_i,
  output      logic                         out_valid_o,
  output      logic [ocbrl_pkg::DataW-1:0]  data_out_o,
  output      logic                         byte_valid_o,
  output      logic                         last_o,
  output      logic [ocbrl_pkg::OffW-1:0]   new_cursor_o,
  output      logic [ocbrl_pkg::OffW-1:0]   missed_bytes_o,
  output      logic [ocbrl_pkg::LimW-1:0]   read_count_o,
  output      logic [ocbrl_pkg::OffW-1:0]   oldest_offset_o,
  output      logic [ocbrl_pkg::UsedW-1:0]  bytes_used_o
);
  import ocbrl_pkg::*;

  localparam int                AddrW   = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
  localparam logic [OffW-1:0]   RingLen = OffW'(RING_BYTES);
  localparam logic [LimW-1:0]   MaxLim  = LimW'(MAX_READ);

  logic [DataW-1:0] mem_q [RING_BYTES];

  logic [OffW-1:0]  wend_q;
  logic [OffW-1:0]  cur_q, oldest_q, start_q, missed_q, ncur_q;
  logic [UsedW-1:0] used_q;
  logic [LimW-1:0]  lim_q, cnt_q, rem_q, left_q;
  logic [AddrW-1:0] raddr_q;
  logic [DataW-1:0] rdata_q;
  logic             rv_q, out_valid_q;

  logic [OffW-1:0]  avail;
  logic [LimW-1:0]  lim_sat, cnt_d;
  logic             out_free;

  // output slot frees when empty or being taken
  assign out_free = !out_valid_q || !out_stall_i;
  assign lim_sat  = (read_limit_i > MaxLim) ? MaxLim : read_limit_i;
  assign avail    = wend_q - start_q;

  always_comb begin
    if (lim_q == '0) begin
      cnt_d = '0;
    end else if ((|avail[OffW-1:LimW]) || (avail[LimW-1:0] > lim_q)) begin
      cnt_d = lim_q;
    end else begin
      cnt_d = avail[LimW-1:0];
    end
  end

  // ring memory, registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.app) begin
      mem_q[wend_q[AddrW-1:0]] <= byte_in_i;
    end
    if (cmd_i.issue) begin
      rdata_q <= mem_q[raddr_q];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wend_q      <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      left_q      <= '0;
    end else begin
      if (cmd_i.app) begin
        wend_q <= wend_q + OffW'(1);
      end
      if (cmd_i.sum) begin
        rem_q  <= cnt_q;
        left_q <= cnt_q;
      end else begin
        if (cmd_i.issue) begin
          rem_q <= rem_q - LimW'(1);
        end
        if (cmd_i.ld_byte) begin
          left_q <= left_q - LimW'(1);
        end
      end
      if (cmd_i.issue) begin
        rv_q <= 1'b1;
      end else if (cmd_i.ld_byte) begin
        rv_q <= 1'b0;
      end
      if (cmd_i.ld_byte || cmd_i.ld_empty) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // read window payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_acc) begin
      cur_q <= cursor_in_i;
      lim_q <= lim_sat;
      if (wend_q > RingLen) begin
        oldest_q <= wend_q - RingLen;
        used_q   <= RingLen[UsedW-1:0];
      end else begin
        oldest_q <= '0;
        used_q   <= wend_q[UsedW-1:0];
      end
    end
    if (cmd_i.clamp) begin
      if (lim_q == '0) begin
        start_q  <= cur_q;
        missed_q <= '0;
      end else if (cur_q > wend_q) begin
        start_q  <= oldest_q;
        missed_q <= '0;
      end else if (cur_q < oldest_q) begin
        start_q  <= oldest_q;
        missed_q <= oldest_q - cur_q;
      end else begin
        start_q  <= cur_q;
        missed_q <= '0;
      end
    end
    if (cmd_i.count) begin
      cnt_q <= cnt_d;
    end
    if (cmd_i.sum) begin
      ncur_q  <= start_q + OffW'(cnt_q);
      raddr_q <= start_q[AddrW-1:0];
    end else if (cmd_i.issue) begin
      raddr_q <= raddr_q + AddrW'(1);
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_byte) begin
      data_out_o      <= rdata_q;
      byte_valid_o    <= 1'b1;
      last_o          <= (left_q == LimW'(1));
      new_cursor_o    <= ncur_q;
      missed_bytes_o  <= missed_q;
      read_count_o    <= cnt_q;
      oldest_offset_o <= oldest_q;
      bytes_used_o    <= used_q;
    end else if (cmd_i.ld_empty) begin
      data_out_o      <= '0;
      byte_valid_o    <= 1'b0;
      last_o          <= 1'b1;
      new_cursor_o    <= start_q;
      missed_bytes_o  <= missed_q;
      read_count_o    <= '0;
      oldest_offset_o <= oldest_q;
      bytes_used_o    <= used_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.cnt_zero  = (cnt_q == '0);
    sts_o.rem_zero  = (rem_q == '0);
    sts_o.rv        = rv_q;
    sts_o.out_free  = out_free;
    sts_o.last_left = (left_q == LimW'(1));
  end

endmodule

`default_nettype wire

FILE: rtl/core/ocbrl_ctrl.sv
// ----------------------------------------------------------------------------
// ocbrl_ctrl
// sequencer for appends, read window setup and byte streaming
// ----------------------------------------------------------------------------
`default_nettype none

module ocbrl_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             operation_i,
  output      logic             in_stall_o,
  input  wire ocbrl_pkg::sts_t  sts_i,
  output      ocbrl_pkg::cmd_t  cmd_o
);
  import ocbrl_pkg::*;

  state_e state_q, state_d;
  logic   acc;

  assign acc = in_valid_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc && (operation_i == OpRead)) begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: state_d = S_COUNT;
      S_COUNT: state_d = S_SUM;
      S_SUM: begin
        state_d = sts_i.cnt_zero ? S_EMPTY : S_STREAM;
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_STREAM: begin
        if (sts_i.rv && sts_i.out_free && sts_i.last_left) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.app    = acc && (operation_i == OpAppend);
        cmd_o.rd_acc = acc && (operation_i == OpRead);
      end
      S_CLAMP: cmd_o.clamp = 1'b1;
      S_COUNT: cmd_o.count = 1'b1;
      S_SUM:   cmd_o.sum   = 1'b1;
      S_EMPTY: cmd_o.ld_empty = sts_i.out_free;
      S_STREAM: begin
        cmd_o.issue   = !sts_i.rem_zero && (!sts_i.rv || sts_i.out_free);
        cmd_o.ld_byte = sts_i.rv && sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/ocbrl_checker.sv
// ----------------------------------------------------------------------------
// ocbrl_checker
// port level checks of the offset cursor byte ring log, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "offset_cursor_byte_ring_log_core_macros.svh"

module ocbrl_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        operation_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [ocbrl_pkg::DataW-1:0] data_out_o,
  input wire logic                        byte_valid_o,
  input wire logic                        last_o,
  input wire logic [ocbrl_pkg::LimW-1:0]  read_count_o
);
  import ocbrl_pkg::*;

  // a stalled result keeps its byte
  `OCBRL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(data_out_o))
  // an empty read is a single final result with no bytes
  `OCBRL_ASSERT_IMPL(a_empty_last, clk_i, rst_ni, out_valid_o && !byte_valid_o, last_o && (read_count_o == '0))
  // a byte result belongs to a read with a nonzero count
  `OCBRL_ASSERT_IMPL(a_byte_count, clk_i, rst_ni, out_valid_o && byte_valid_o, read_count_o != '0)
  // an accepted read blocks the input while its window is worked out
  `OCBRL_ASSERT_NEXT(a_read_stall, clk_i, rst_ni, in_valid_i && !in_stall_o && (operation_i == OpRead), in_stall_o)

endmodule

bind offset_cursor_byte_ring_log_core ocbrl_checker u_ocbrl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .operation_i  (operation_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .data_out_o   (data_out_o),
  .byte_valid_o (byte_valid_o),
  .last_o       (last_o),
  .read_count_o (read_count_o)
);

`default_nettype wire

FILE: tb/offset_cursor_byte_ring_log_core_test.sv
// ----------------------------------------------------------------------------
// offset_cursor_byte_ring_log_core_test
// drives appends and read requests into the byte ring log, predicts every
// streamed read byte from a shadow ring, and checks each result transaction
// ----------------------------------------------------------------------------

module offset_cursor_byte_ring_log_core_test;
  import ocbrl_pkg::*;

  localparam int RingBytes     = RingBytesDef;
  localparam int MaxRead       = MaxReadDef;
  localparam int ReadRequests  = 43;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 80;
  localparam int PrintCap      = 40;

  // one input transaction as queued for the driver
  typedef struct {
    logic             op;
    logic [DataW-1:0] data;
    logic [OffW-1:0]  cursor;
    logic [LimW-1:0]  limit;
  } log_item_t;

  // one predicted result transaction of a read
  typedef struct {
    logic [DataW-1:0] data;
    logic             byte_valid;
    logic             last;
    logic [OffW-1:0]  new_cursor;
    logic [OffW-1:0]  missed;
    logic [LimW-1:0]  count;
    logic [OffW-1:0]  oldest;
    logic [UsedW-1:0] used;
  } read_beat_t;

  // dut ports; the inputs are all known from time zero
  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             operation_i  = OpAppend;
  logic [DataW-1:0] byte_in_i    = '0;
  logic [OffW-1:0]  cursor_in_i  = '0;
  logic [LimW-1:0]  read_limit_i = '0;
  logic             out_stall_i  = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [DataW-1:0] data_out_o;
  logic             byte_valid_o;
  logic             last_o;
  logic [OffW-1:0]  new_cursor_o;
  logic [OffW-1:0]  missed_bytes_o;
  logic [LimW-1:0]  read_count_o;
  logic [OffW-1:0]  oldest_offset_o;
  logic [UsedW-1:0] bytes_used_o;

  // transactions still to offer, and read bytes still to arrive
  log_item_t  item_q[$];
  read_beat_t beat_q[$];

  // shadow copy of the ring and its write offset
  logic [DataW-1:0] shadow_ring [RingBytes];
  logic [OffW-1:0]  shadow_end = '0;

  // write offset as seen while building the stimulus
  logic [OffW-1:0]  gen_end = '0;

  int total_items   = 0;
  int n_in_acc      = 0;
  int mismatches    = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 73;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int quiet_cycles  = 0;
  log_item_t cur_item;

  offset_cursor_byte_ring_log_core #(
    .RING_BYTES(RingBytes),
    .MAX_READ  (MaxRead)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .byte_in_i      (byte_in_i),
    .cursor_in_i    (cursor_in_i),
    .read_limit_i   (read_limit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_out_o     (data_out_o),
    .byte_valid_o   (byte_valid_o),
    .last_o         (last_o),
    .new_cursor_o   (new_cursor_o),
    .missed_bytes_o (missed_bytes_o),
    .read_count_o   (read_count_o),
    .oldest_offset_o(oldest_offset_o),
    .bytes_used_o   (bytes_used_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow ring update and read prediction, applied per accepted transaction
  task automatic apply_item(input log_item_t it);
    logic [OffW-1:0]  oldest;
    logic [OffW-1:0]  start;
    logic [OffW-1:0]  missed;
    logic [OffW-1:0]  count;
    logic [OffW-1:0]  limit;
    logic [OffW-1:0]  used;
    read_beat_t       b;
    oldest = (shadow_end > RingBytes) ? shadow_end - RingBytes : '0;
    used   = (shadow_end > RingBytes) ? 64'(RingBytes) : shadow_end;
    if (it.op == OpAppend) begin
      shadow_ring[shadow_end & (RingBytes - 1)] = it.data;
      shadow_end = shadow_end + 1;
      return;
    end
    // limits above the read maximum saturate
    limit  = (it.limit > MaxRead) ? 64'(MaxRead) : 64'(it.limit);
    start  = it.cursor;
    missed = '0;
    count  = '0;
    // a zero limit leaves the cursor untouched
    if (limit != 0) begin
      if (start > shadow_end) begin
        // past the end: restart at the oldest byte, nothing reported lost
        start = oldest;
      end else if (start < oldest) begin
        // overwritten bytes: clamp and report how many were missed
        missed = oldest - start;
        start  = oldest;
      end
      count = shadow_end - start;
      if (count > limit) count = limit;
    end
    b.missed = missed;
    b.oldest = oldest;
    b.used   = used[UsedW-1:0];
    if (count == 0) begin
      // zero limit or nothing left to read: a single empty transaction
      b.data       = '0;
      b.byte_valid = 1'b0;
      b.last       = 1'b1;
      b.new_cursor = start;
      b.count      = '0;
      beat_q.push_back(b);
    end else begin
      for (int k = 0; k < count; k++) begin
        b.data       = shadow_ring[(start + k) & (RingBytes - 1)];
        b.byte_valid = 1'b1;
        b.last       = (k + 1 == count);
        b.new_cursor = start + count;
        b.count      = count[LimW-1:0];
        beat_q.push_back(b);
      end
    end
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < PrintCap)
      $display("mismatch %s: got %h want %h", field, got, want);
    mismatches++;
  endtask

  task automatic push_append(input logic [DataW-1:0] data);
    log_item_t it;
    it.op     = OpAppend;
    it.data   = data;
    // cursor and limit are don't-care for appends, fill them with noise
    it.cursor = {$urandom, $urandom};
    it.limit  = LimW'($urandom);
    item_q.push_back(it);
    gen_end = gen_end + 1;
  endtask

  task automatic push_read(input logic [OffW-1:0] cursor, input logic [LimW-1:0] limit);
    log_item_t it;
    it.op     = OpRead;
    it.data   = DataW'($urandom);
    it.cursor = cursor;
    it.limit  = limit;
    item_q.push_back(it);
  endtask

  // driver: offers queued transactions, holds each until it is accepted
  always @(posedge clk_i) begin : drive_blk
    bit offered;
    if (rst_ni) begin
      offered = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        apply_item(cur_item);
        n_in_acc++;
        offered = 1'b0;
        // idle profile by thirds of the run: sender light, then receiver
        // light, then no idling at all
        if (n_in_acc * 3 >= total_items * 2) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end else if (n_in_acc * 3 >= total_items) begin
          send_idle_pct = 73;
          recv_idle_pct = 9;
        end
      end
      if (!offered) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = item_q.pop_front();
          in_valid_i   <= 1'b1;
          operation_i  <= cur_item.op;
          byte_in_i    <= cur_item.data;
          cursor_in_i  <= cur_item.cursor;
          read_limit_i <= cur_item.limit;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk_i) begin : check_blk
    read_beat_t exp;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (beat_q.size() == 0) begin
          report_mismatch("unexpected result, data_out", 64'(data_out_o), '0);
        end else begin
          exp = beat_q.pop_front();
          if (data_out_o !== exp.data)
            report_mismatch("data_out", 64'(data_out_o), 64'(exp.data));
          if (byte_valid_o !== exp.byte_valid)
            report_mismatch("byte_valid", 64'(byte_valid_o), 64'(exp.byte_valid));
          if (last_o !== exp.last)
            report_mismatch("last", 64'(last_o), 64'(exp.last));
          if (new_cursor_o !== exp.new_cursor)
            report_mismatch("new_cursor", new_cursor_o, exp.new_cursor);
          if (missed_bytes_o !== exp.missed)
            report_mismatch("missed_bytes", missed_bytes_o, exp.missed);
          if (read_count_o !== exp.count)
            report_mismatch("read_count", 64'(read_count_o), 64'(exp.count));
          if (oldest_offset_o !== exp.oldest)
            report_mismatch("oldest_offset", oldest_offset_o, exp.oldest);
          if (bytes_used_o !== exp.used)
            report_mismatch("bytes_used", 64'(bytes_used_o), 64'(exp.used));
        end
      end
      // one long hold-off in the no-idle third while a read is in flight,
      // so the block backs up and stalls its input
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!hold_done && send_idle_pct == 0 && beat_q.size() != 0) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // watchdog: too long without any accepted transaction ends the run
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [OffW-1:0] oldest;
    logic [OffW-1:0] span;
    logic [OffW-1:0] cursor;
    logic [LimW-1:0] limit;
    int              burst;
    int              pick;
    int              back;

    // directed: empty ring, zero limit, byte extremes, saturated limit,
    // cursor beyond the end, cursor at the end with no data
    push_read(64'd0, 7'd8);
    push_read('1, 7'd0);
    push_append(8'h00);
    push_append(8'hff);
    push_append(8'ha5);
    push_append(8'h5a);
    push_append(8'h01);
    push_append(8'h80);
    push_read(64'd0, 7'd127);
    push_read(64'd0, 7'(MaxRead));
    push_read(64'd3, 7'd1);
    push_read('1, 7'd2);
    push_read(64'd7, 7'd4);
    push_read(64'd6, 7'd4);
    push_read(64'h8000_0000_0000_0000, 7'd0);
    push_read(64'd5, 7'd64);

    // random: short append bursts with reads in between
    for (int i = 0; i < ReadRequests; i++) begin
      burst = $urandom_range(0, 8);
      for (int j = 0; j < burst; j++) push_append(DataW'($urandom));
      oldest = (gen_end > RingBytes) ? gen_end - RingBytes : '0;
      span   = gen_end - oldest;
      pick   = $urandom_range(0, 99);
      if (pick < 25) begin
        // just behind the write end
        back   = $urandom_range(0, 100);
        cursor = (back > span) ? oldest : gen_end - back;
      end else if (pick < 45) begin
        cursor = oldest + $urandom_range(0, int'(span));
      end else if (pick < 52) begin
        cursor = '0;
      end else if (pick < 62) begin
        // behind the oldest byte once the ring has wrapped
        if (oldest > 5000) cursor = oldest - $urandom_range(1, 5000);
        else if (oldest != 0) cursor = oldest - $urandom_range(1, int'(oldest));
        else cursor = '0;
      end else if (pick < 74) begin
        cursor = gen_end + $urandom_range(1, 200);
      end else if (pick < 82) begin
        cursor = gen_end;
      end else begin
        cursor = {$urandom, $urandom};
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) limit = '0;
      else if (pick < 20) limit = LimW'($urandom_range(MaxRead + 1, 127));
      else limit = LimW'($urandom_range(1, MaxRead));
      push_read(cursor, limit);
    end
    total_items = item_q.size();

    // reset is held at the start, then released once
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_in_acc < total_items) @(posedge clk_i);
    while (beat_q.size() != 0) @(posedge clk_i);
    // room for any stray transaction after the last expected one
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ocbrl_pkg.sv
rtl/core/ocbrl_datapath.sv
rtl/core/ocbrl_ctrl.sv
rtl/core/offset_cursor_byte_ring_log_core.sv
rtl/core/ocbrl_checker.sv
tb/offset_cursor_byte_ring_log_core_test.sv
